### rtl/spq_pkg.sv
// Shared constants and types for the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  // Number of slots in the cell chain
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths
  localparam int VAL_W    = 32;
  localparam int PRI_W    = 16;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;
  localparam int ECNT_W   = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Packed stream widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 64;

  // Broadcast from the control to every cell
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [VAL_W-1:0] value;
    logic signed [PRI_W-1:0] prio;
    logic [CNT_W-1:0]        count;
  } spq_ctrl_t;

endpackage
`default_nettype wire

### rtl/stable_priority_queue.sv
// Top level of the stable priority queue: cell chain, count and result register.
//
//   Channel  | Direction | Handshake          | Payload
//   in_      | slave     | in_tvalid/tready   | in_tdata: opcode, item_value, item_priority
//   out_     | master    | out_tvalid/tready  | out_tdata: status, count, flags, head entry
//
// One item is taken per cycle while in_tready is high; its result appears in the output
// register in the next cycle. The row of cells compares every slot with the new priority at
// once and shifts in the same edge, so no operation iterates.
// Reset clears the count and the output valid flag; slot contents are not cleared.
// in_tready drops only while a result waits and out_tready is low.
`timescale 1ns / 1ps
`default_nettype none
module stable_priority_queue (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // [1:0] opcode, [33:2] item_value, [49:34] item_priority, [55:50] zero
  input  wire logic [spq_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [1:0] status, [6:2] entry_count, [7] queue_empty, [8] queue_full,
  // [9] head_valid, [41:10] head_value, [57:42] head_priority, [63:58] zero
  output logic [spq_pkg::OUT_DATA_W-1:0]          out_tdata
);

  localparam int CAP = spq_pkg::CAPACITY;

  logic                               in_acc;
  logic [spq_pkg::OP_W-1:0]           in_op;
  logic signed [spq_pkg::VAL_W-1:0]   in_value;
  logic signed [spq_pkg::PRI_W-1:0]   in_prio;

  logic [spq_pkg::CNT_W-1:0]          count_r;
  logic [spq_pkg::CNT_W-1:0]          count_nxt;
  logic                               is_full;
  logic                               is_empty;
  logic [spq_pkg::STAT_W-1:0]         status;
  spq_pkg::spq_ctrl_t                 ctrl;

  logic                               out_valid_r;
  logic [spq_pkg::OUT_DATA_W-1:0]     out_data_r;
  logic [spq_pkg::OUT_DATA_W-1:0]     out_data_nxt;

  logic                               cell_keep  [CAP];
  logic signed [spq_pkg::VAL_W-1:0]   cell_value [CAP];
  logic signed [spq_pkg::PRI_W-1:0]   cell_prio  [CAP];
  logic signed [spq_pkg::VAL_W-1:0]   cell_nvalue[CAP];
  logic signed [spq_pkg::PRI_W-1:0]   cell_nprio [CAP];

  logic                               head_valid;
  logic signed [spq_pkg::VAL_W-1:0]   head_value;
  logic signed [spq_pkg::PRI_W-1:0]   head_prio;

  // Unpack the input item
  assign in_op     = in_tdata[1:0];
  assign in_value  = in_tdata[33:2];
  assign in_prio   = in_tdata[49:34];
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign is_full  = count_r == spq_pkg::CNT_W'(CAP);
  assign is_empty = count_r == '0;

  // Decode the operation and drop what cannot be done
  always_comb begin
    ctrl.ins   = in_acc && (in_op == spq_pkg::OP_INSERT) && !is_full;
    ctrl.rem   = in_acc && (in_op == spq_pkg::OP_REMOVE) && !is_empty;
    ctrl.value = in_value;
    ctrl.prio  = in_prio;
    ctrl.count = count_r;
    status     = spq_pkg::ST_OK;
    if (in_op == spq_pkg::OP_INSERT && is_full) begin
      status = spq_pkg::ST_FULL;
    end else if (in_op == spq_pkg::OP_REMOVE && is_empty) begin
      status = spq_pkg::ST_EMPTY;
    end
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + spq_pkg::CNT_W'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - spq_pkg::CNT_W'(1);
    end
  end

  // Row of slot cells, head at index zero
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic                             l_keep;
    logic signed [spq_pkg::VAL_W-1:0] l_value;
    logic signed [spq_pkg::PRI_W-1:0] l_prio;
    logic signed [spq_pkg::VAL_W-1:0] r_value;
    logic signed [spq_pkg::PRI_W-1:0] r_prio;

    if (i == 0) begin : g_first
      assign l_keep  = 1'b1;
      assign l_value = cell_value[i];
      assign l_prio  = cell_prio[i];
    end else begin : g_mid
      assign l_keep  = cell_keep[i-1];
      assign l_value = cell_value[i-1];
      assign l_prio  = cell_prio[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign r_value = cell_value[i];
      assign r_prio  = cell_prio[i];
    end else begin : g_inner
      assign r_value = cell_value[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .slot_idx    (spq_pkg::IDX_W'(i)),
      .left_keep   (l_keep),
      .left_value  (l_value),
      .left_prio   (l_prio),
      .right_value (r_value),
      .right_prio  (r_prio),
      .keep        (cell_keep[i]),
      .slot_value  (cell_value[i]),
      .slot_prio   (cell_prio[i]),
      .nxt_value   (cell_nvalue[i]),
      .nxt_prio    (cell_nprio[i])
    );
  end

  // Head after the operation, zero when nothing is stored
  assign head_valid = count_nxt != '0;
  assign head_value = head_valid ? cell_nvalue[0] : '0;
  assign head_prio  = head_valid ? cell_nprio[0]  : '0;

  // Pack the result item
  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[1:0]   = status;
    out_data_nxt[6:2]   = spq_pkg::ECNT_W'(count_nxt);
    out_data_nxt[7]     = count_nxt == '0;
    out_data_nxt[8]     = count_nxt == spq_pkg::CNT_W'(CAP);
    out_data_nxt[9]     = head_valid;
    out_data_nxt[41:10] = head_value;
    out_data_nxt[57:42] = head_prio;
  end

  // Hold the count and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // Count never passes the number of slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spq_pkg::CNT_W'(CAP))
    else $error("stored count exceeds capacity");

  // An accepted insert with room grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_op == spq_pkg::OP_INSERT && !is_full)
      |=> count_r == $past(count_r) + spq_pkg::CNT_W'(1))
    else $error("insert did not grow the count");

  // Reported head is valid exactly when the queue is not empty
  a_head_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[9] == !out_data_r[7]))
    else $error("head valid disagrees with empty flag");
`endif

endmodule
`default_nettype wire

### rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell (
  input  wire logic                              clk,
  input  wire spq_pkg::spq_ctrl_t                ctrl,
  input  wire logic [spq_pkg::IDX_W-1:0]         slot_idx,
  input  wire logic                              left_keep,
  input  wire logic signed [spq_pkg::VAL_W-1:0]  left_value,
  input  wire logic signed [spq_pkg::PRI_W-1:0]  left_prio,
  input  wire logic signed [spq_pkg::VAL_W-1:0]  right_value,
  input  wire logic signed [spq_pkg::PRI_W-1:0]  right_prio,
  output logic                                   keep,
  output logic signed [spq_pkg::VAL_W-1:0]       slot_value,
  output logic signed [spq_pkg::PRI_W-1:0]       slot_prio,
  output logic signed [spq_pkg::VAL_W-1:0]       nxt_value,
  output logic signed [spq_pkg::PRI_W-1:0]       nxt_prio
);

  logic signed [spq_pkg::VAL_W-1:0] value_r;
  logic signed [spq_pkg::PRI_W-1:0] prio_r;
  logic                             occupied;

  assign occupied   = spq_pkg::CNT_W'(slot_idx) < ctrl.count;
  // Hold position when the stored entry ranks at or above the new one
  assign keep       = occupied && (prio_r >= ctrl.prio);
  assign slot_value = value_r;
  assign slot_prio  = prio_r;

  // Choose the next contents: stay, take the new entry, or shift
  always_comb begin
    nxt_value = value_r;
    nxt_prio  = prio_r;
    if (ctrl.ins) begin
      if (keep) begin
        nxt_value = value_r;
        nxt_prio  = prio_r;
      end else if (left_keep) begin
        nxt_value = ctrl.value;
        nxt_prio  = ctrl.prio;
      end else begin
        nxt_value = left_value;
        nxt_prio  = left_prio;
      end
    end else if (ctrl.rem) begin
      nxt_value = right_value;
      nxt_prio  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= nxt_value;
    prio_r  <= nxt_prio;
  end

endmodule
`default_nettype wire

### test/stable_priority_queue_tb.sv
// Self-checking testbench for the stable priority queue: predicted results and stream handshakes.
`timescale 1ns / 1ps
module stable_priority_queue_tb;

  // Opcodes beyond those the package names
  localparam logic [spq_pkg::OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [spq_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  localparam int RESET_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASE_ITEMS  = 310;

  // Mix of operations within a random stretch
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

  // Input item, lowest field in the lowest bits
  typedef struct packed {
    logic [5:0]                       pad;
    logic signed [spq_pkg::PRI_W-1:0] prio;
    logic signed [spq_pkg::VAL_W-1:0] value;
    logic [spq_pkg::OP_W-1:0]         op;
  } spq_item_t;

  // Result item, lowest field in the lowest bits
  typedef struct packed {
    logic [5:0]                       pad;
    logic signed [spq_pkg::PRI_W-1:0] head_prio;
    logic signed [spq_pkg::VAL_W-1:0] head_value;
    logic                             head_valid;
    logic                             full;
    logic                             empty;
    logic [spq_pkg::ECNT_W-1:0]       count;
    logic [spq_pkg::STAT_W-1:0]       status;
  } spq_result_t;

  // Ordered copy of the slots and the queue status each operation reports
  class spq_scoreboard;
    logic signed [spq_pkg::VAL_W-1:0] slot_value[spq_pkg::CAPACITY];
    logic signed [spq_pkg::PRI_W-1:0] slot_prio[spq_pkg::CAPACITY];
    int                               held;
    spq_result_t                      awaited_status[$];
    int                               errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    // Apply one accepted operation to the slots and queue up its status
    function void apply_operation(spq_item_t it);
      spq_result_t                      r;
      logic signed [spq_pkg::PRI_W-1:0] p;
      int                               pos;
      r = '0;
      r.status = spq_pkg::ST_OK;
      p = it.prio;
      if (it.op == spq_pkg::OP_INSERT) begin
        if (held >= spq_pkg::CAPACITY) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          // Go past every entry of greater or equal priority
          pos = 0;
          while (pos < held && slot_prio[pos] >= p) pos++;
          for (int i = held; i > pos; i--) begin
            slot_value[i] = slot_value[i-1];
            slot_prio[i]  = slot_prio[i-1];
          end
          slot_value[pos] = it.value;
          slot_prio[pos]  = p;
          held++;
        end
      end else if (it.op == spq_pkg::OP_REMOVE) begin
        if (held == 0) begin
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i + 1 < held; i++) begin
            slot_value[i] = slot_value[i+1];
            slot_prio[i]  = slot_prio[i+1];
          end
          held--;
        end
      end
      r.count = held[spq_pkg::ECNT_W-1:0];
      r.empty = (held == 0);
      r.full  = (held == spq_pkg::CAPACITY);
      if (held > 0) begin
        r.head_valid = 1'b1;
        r.head_value = slot_value[0];
        r.head_prio  = slot_prio[0];
      end
      awaited_status.push_back(r);
    endfunction

    task flag_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    // Compare one result with the oldest awaited status
    task check_status(input spq_result_t got);
      spq_result_t want;
      if (awaited_status.size() == 0) begin
        flag_mismatch("unexpected result", got, 64'd0);
      end else begin
        want = awaited_status.pop_front();
        if (got.status !== want.status)
          flag_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.count !== want.count)
          flag_mismatch("entry_count", 64'(got.count), 64'(want.count));
        if (got.empty !== want.empty)
          flag_mismatch("queue_empty", 64'(got.empty), 64'(want.empty));
        if (got.full !== want.full)
          flag_mismatch("queue_full", 64'(got.full), 64'(want.full));
        if (got.head_valid !== want.head_valid)
          flag_mismatch("head_valid", 64'(got.head_valid), 64'(want.head_valid));
        if (got.head_value !== want.head_value)
          flag_mismatch("head_value", 64'(got.head_value), 64'(want.head_value));
        if (got.head_prio !== want.head_prio)
          flag_mismatch("head_priority", 64'(got.head_prio), 64'(want.head_prio));
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [spq_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [spq_pkg::OUT_DATA_W-1:0] out_tdata;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int quiet_cycles = 0;

  spq_scoreboard sb = new();

  stable_priority_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(input logic [spq_pkg::OP_W-1:0] op,
                           input logic [spq_pkg::VAL_W-1:0] val,
                           input logic [spq_pkg::PRI_W-1:0] pri);
    spq_item_t it;
    it = '0;
    it.op = op;
    it.value = val;
    it.prio = pri;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.apply_operation(it);
  endtask

  // Random operations in stretches that fill, drain or churn the queue
  task automatic send_random(input int n);
    op_mix_t                   mix;
    int                        roll;
    logic [spq_pkg::OP_W-1:0]  op;
    logic [spq_pkg::PRI_W-1:0] pri;
    mix = MIX_EVEN;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) mix = op_mix_t'($urandom_range(2));
      roll = $urandom_range(99);
      case (mix)
        MIX_FILL: begin
          op = (roll < 70) ? spq_pkg::OP_INSERT : (roll < 92) ? spq_pkg::OP_REMOVE :
               (roll < 97) ? OP_QUERY : OP_SPARE;
        end
        MIX_DRAIN: begin
          op = (roll < 25) ? spq_pkg::OP_INSERT : (roll < 90) ? spq_pkg::OP_REMOVE :
               (roll < 96) ? OP_QUERY : OP_SPARE;
        end
        default: begin
          op = (roll < 45) ? spq_pkg::OP_INSERT : (roll < 88) ? spq_pkg::OP_REMOVE :
               (roll < 95) ? OP_QUERY : OP_SPARE;
        end
      endcase
      // Narrow priorities give plenty of ties
      case ($urandom_range(3))
        0, 1:    pri = spq_pkg::PRI_W'($urandom_range(4)) - spq_pkg::PRI_W'(2);
        2:       pri = spq_pkg::PRI_W'($urandom());
        default: pri = $urandom_range(1) ? 16'h7fff : 16'h8000;
      endcase
      send_item(op, $urandom(), pri);
    end
  endtask

  // Receiver: random stalls, or a long hold-off when asked
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every result taken
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_status(out_tdata);
  end

  // Abort when neither side moves an item for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty queue, spare opcode and ignored operands
    send_item(OP_QUERY, 32'h0, 16'h0);
    send_item(spq_pkg::OP_REMOVE, 32'h5a5a5a5a, 16'h1234);
    send_item(OP_SPARE, 32'hffffffff, 16'hffff);
    // Extremes of value and priority, then ties kept in arrival order
    send_item(spq_pkg::OP_INSERT, 32'h7fffffff, 16'h7fff);
    send_item(spq_pkg::OP_INSERT, 32'h80000000, 16'h8000);
    send_item(spq_pkg::OP_INSERT, 32'h1, 16'h0);
    send_item(spq_pkg::OP_INSERT, 32'h2, 16'h0);
    send_item(spq_pkg::OP_INSERT, 32'h3, 16'h0);
    send_item(spq_pkg::OP_INSERT, 32'h4, 16'h7fff);
    send_item(spq_pkg::OP_INSERT, 32'hffffffff, 16'hffff);
    send_item(spq_pkg::OP_INSERT, 32'h0, 16'h1);
    for (int i = 0; i < 8; i++) send_item(spq_pkg::OP_INSERT, 32'h100 + i, 16'h8000);
    // Insert on a full queue is dropped
    send_item(spq_pkg::OP_INSERT, 32'h5, 16'h7fff);
    send_item(OP_QUERY, 32'h0, 16'h0);
    repeat (3) send_item(spq_pkg::OP_REMOVE, 32'h0, 16'h0);

    // No idling, with one long receiver hold-off in the middle
    send_random(PHASE_ITEMS / 2);
    hold_request = HOLD_CYCLES;
    send_random(PHASE_ITEMS - PHASE_ITEMS / 2);
    // Sender mostly idle
    send_idle_pct = 71;
    send_random(PHASE_ITEMS);
    // Receiver mostly stalling
    send_idle_pct = 0;
    recv_stall_pct = 71;
    send_random(PHASE_ITEMS);
    // Both sides idling
    send_idle_pct = 36;
    recv_stall_pct = 36;
    send_random(PHASE_ITEMS);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.awaited_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
